>>> sv/atdg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atdg_pkg
// Shared widths, register map codes and the interface types between the
// descriptor sequencer and the ceiling divider.
// ----------------------------------------------------------------------------
package atdg_pkg;

   // Field widths fixed by the descriptor format.
   localparam int TOKEN_W   = 13;
   localparam int QPOS_W    = 31;
   localparam int SEEN_W    = 24;
   localparam int GPOS_W    = 25;
   localparam int TABLE_W   = 64;
   localparam int ATOM_OUT_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Tile limit per sequence and the smallest tile size honored.
   localparam int RESULT_LIMIT = 64;
   localparam int COUNT_W      = $clog2(RESULT_LIMIT);
   localparam logic [TOKEN_W-1:0] TILE_FLOOR = 13'd64;

   // Ceiling divider sizing: dividend is extent plus divisor minus one.
   localparam int DIVIDEND_W = GPOS_W + 1;
   localparam int DIVISOR_W  = TOKEN_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Register indexes, decoded from the word address bit.
   localparam logic REG_QUERY_TILE_SIZE = 1'b0;
   localparam logic REG_KV_BLOCK_SIZE   = 1'b1;

   // Divider control and status.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

>>> sv/atdg_ceil_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atdg_ceil_div
// Bit-serial restoring divider, one quotient bit per cycle. The caller
// presents the already biased dividend, so the quotient is the ceiling.
// ----------------------------------------------------------------------------
module atdg_ceil_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire atdg_pkg::div_ctrl_type           ctrl,
   input  wire logic [atdg_pkg::DIVIDEND_W-1:0]  dividend,
   input  wire logic [atdg_pkg::DIVISOR_W-1:0]   divisor,
   output logic [atdg_pkg::DIVIDEND_W-1:0]       quotient,
   output atdg_pkg::div_status_type              status
);
   import atdg_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor};
      fits      = rem_shift >= {1'b0, divisor};
   end

   // Sequencing of the steps.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

>>> sv/attention_tile_descriptor_generator_top.sv
`default_nettype none
// Each tile goes through an issue step, 26 divider steps, a finish step and an emit step.
// A sequence of n tiles (n at most 64) keeps the input busy until its last tile is emitted.
// The rate is set by the bit-serial ceiling divider, one quotient bit per cycle, unless rsp_ready stalls the emit.
// A sequence with zero tokens is accepted and emits nothing.
// Synchronous active-high reset clears the sequencer, atom counter and valids,
// and loads both size registers with 64.
// ----------------------------------------------------------------------------
// attention_tile_descriptor_generator_top
// Cuts each sequence descriptor into query tiles and emits one tile
// descriptor per tile, with a key/value block count from a shared divider.
// ----------------------------------------------------------------------------
module attention_tile_descriptor_generator_top #(
   parameter int MAX_SEQ_TOKENS  = 4096,
   parameter int ATOM_INDEX_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Sequence beats.
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_new_batch,
   input  wire logic [atdg_pkg::TOKEN_W-1:0]       req_seq_tokens,
   input  wire logic [atdg_pkg::QPOS_W-1:0]        req_seq_start,
   input  wire logic [atdg_pkg::SEEN_W-1:0]        req_seen_tokens,
   input  wire logic [atdg_pkg::TABLE_W-1:0]       req_block_table_in,
   // Tile descriptor beats.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [atdg_pkg::ATOM_OUT_W-1:0]         rsp_atom_index,
   output logic [atdg_pkg::TABLE_W-1:0]            rsp_block_table_out,
   output logic [atdg_pkg::QPOS_W-1:0]             rsp_q_start,
   output logic [atdg_pkg::TOKEN_W-1:0]            rsp_q_len,
   output logic [atdg_pkg::GPOS_W-1:0]             rsp_global_q_start,
   output logic [atdg_pkg::GPOS_W-1:0]             rsp_total_extent,
   output logic [atdg_pkg::GPOS_W-1:0]             rsp_kv_block_count,
   output logic                                    rsp_last_tile,
   // Register port.
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [atdg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [atdg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [atdg_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);
   import atdg_pkg::*;

   localparam int MAX_TOK_W = $clog2(MAX_SEQ_TOKENS + 1) > TOKEN_W ?
                              $clog2(MAX_SEQ_TOKENS + 1) : TOKEN_W;
   localparam logic [MAX_TOK_W-1:0] MAX_TOK = MAX_TOK_W'(MAX_SEQ_TOKENS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [TOKEN_W-1:0]         qtile_ff, qtile_in;
   logic [TOKEN_W-1:0]         kvb_ff, kvb_in;
   logic [ATOM_INDEX_BITS-1:0] atom_ff, atom_in;
   logic [TOKEN_W-1:0]         remain_ff, remain_in;
   logic [QPOS_W-1:0]          qpos_ff, qpos_in;
   logic [GPOS_W-1:0]          gpos_ff, gpos_in;
   logic [TABLE_W-1:0]         table_ff, table_in;
   logic [COUNT_W-1:0]         count_ff, count_in;

   logic                       out_valid_ff, out_valid_in;
   logic [ATOM_OUT_W-1:0]      out_atom_ff;
   logic [TABLE_W-1:0]         out_table_ff;
   logic [QPOS_W-1:0]          out_qpos_ff;
   logic [TOKEN_W-1:0]         out_len_ff;
   logic [GPOS_W-1:0]          out_gpos_ff;
   logic [GPOS_W-1:0]          out_extent_ff;
   logic [GPOS_W-1:0]          out_blocks_ff;
   logic                       out_last_ff;

   logic                       cfg_write;
   logic                       req_take;
   logic                       emit_load;
   logic [TOKEN_W-1:0]         tile_eff;
   logic [TOKEN_W-1:0]         kvb_eff;
   logic [TOKEN_W-1:0]         tile_len;
   logic [TOKEN_W-1:0]         remain_next;
   logic [GPOS_W-1:0]          extent;
   logic                       tile_last;
   logic [TOKEN_W-1:0]         tokens_sat;
   logic [31:0]                atom_wide;
   logic [DIVIDEND_W-1:0]      div_dividend;
   logic [DIVIDEND_W-1:0]      div_quotient;
   div_ctrl_type               div_ctrl;
   div_status_type             div_status;

   // Register port: writes land in the access phase, reads are immediate.
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      qtile_in = qtile_ff;
      kvb_in   = kvb_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            REG_QUERY_TILE_SIZE: qtile_in = pwdata[TOKEN_W-1:0];
            REG_KV_BLOCK_SIZE:   kvb_in   = pwdata[TOKEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_QUERY_TILE_SIZE: prdata = CSR_DATA_W'(qtile_ff);
         REG_KV_BLOCK_SIZE:   prdata = CSR_DATA_W'(kvb_ff);
         default:             prdata = '0;
      endcase
   end

   // Tile geometry for the current tile.
   always_comb begin
      tile_eff     = (qtile_ff < TILE_FLOOR) ? TILE_FLOOR : qtile_ff;
      kvb_eff      = (kvb_ff == '0) ? TOKEN_W'(1) : kvb_ff;
      tile_len     = (remain_ff < tile_eff) ? remain_ff : tile_eff;
      remain_next  = remain_ff - tile_len;
      extent       = gpos_ff + GPOS_W'(tile_len);
      tile_last    = (remain_next == '0) || (count_ff == COUNT_W'(RESULT_LIMIT - 1));
      div_dividend = DIVIDEND_W'(extent) + DIVIDEND_W'(kvb_eff) - DIVIDEND_W'(1);
      tokens_sat   = (MAX_TOK_W'(req_seq_tokens) > MAX_TOK) ?
                     MAX_TOK[TOKEN_W-1:0] : req_seq_tokens;
      atom_wide    = 32'(atom_ff);
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_take      = req_valid & req_ready;
   assign emit_load     = (state_ff == ST_EMIT) & (~out_valid_ff | rsp_ready);
   assign div_ctrl.start = (state_ff == ST_START);

   // Sequencer: accept a sequence, then divide and emit tile by tile.
   always_comb begin
      state_in  = state_ff;
      atom_in   = atom_ff;
      remain_in = remain_ff;
      qpos_in   = qpos_ff;
      gpos_in   = gpos_ff;
      table_in  = table_ff;
      count_in  = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_new_batch) begin
                  atom_in = '0;
               end
               remain_in = tokens_sat;
               qpos_in   = req_seq_start;
               gpos_in   = GPOS_W'(req_seen_tokens);
               table_in  = req_block_table_in;
               count_in  = '0;
               state_in  = (tokens_sat == '0) ? ST_IDLE : ST_START;
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               atom_in   = atom_ff + 1'b1;
               remain_in = remain_next;
               qpos_in   = qpos_ff + QPOS_W'(tile_len);
               gpos_in   = extent;
               count_in  = count_ff + 1'b1;
               state_in  = tile_last ? ST_IDLE : ST_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register valid.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qtile_ff     <= TOKEN_W'(64);
         kvb_ff       <= TOKEN_W'(64);
         atom_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qtile_ff     <= qtile_in;
         kvb_ff       <= kvb_in;
         atom_ff      <= atom_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Sequence working registers.
   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      qpos_ff   <= qpos_in;
      gpos_ff   <= gpos_in;
      table_ff  <= table_in;
      count_ff  <= count_in;
   end

   // Tile descriptor output register.
   always_ff @(posedge clock) begin
      if (emit_load) begin
         out_atom_ff   <= atom_wide[ATOM_OUT_W-1:0];
         out_table_ff  <= table_ff;
         out_qpos_ff   <= qpos_ff;
         out_len_ff    <= tile_len;
         out_gpos_ff   <= gpos_ff;
         out_extent_ff <= extent;
         out_blocks_ff <= div_quotient[GPOS_W-1:0];
         out_last_ff   <= tile_last;
      end
   end

   // Shared ceiling divider.
   atdg_ceil_div u_ceil_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (kvb_eff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_atom_index      = out_atom_ff;
   assign rsp_block_table_out = out_table_ff;
   assign rsp_q_start         = out_qpos_ff;
   assign rsp_q_len           = out_len_ff;
   assign rsp_global_q_start  = out_gpos_ff;
   assign rsp_total_extent    = out_extent_ff;
   assign rsp_kv_block_count  = out_blocks_ff;
   assign rsp_last_tile       = out_last_ff;

`ifndef ASSERT_OFF
   // The divider is never busy while a new sequence can be accepted.
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_status.busy)
      else $error("divider busy while sequencer idle");

   // A finished division moves the sequencer to the emit step.
   a_done_to_emit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WAIT) && div_status.done) |=> (state_ff == ST_EMIT))
      else $error("division result not taken");

   // Tiles are only emitted while tokens remain.
   a_emit_has_tokens: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (remain_ff != '0))
      else $error("emit with no tokens left");

   // A shown descriptor is never empty and its extent is consistent.
   a_desc_consistent: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_len_ff != '0) &&
                        (out_extent_ff == out_gpos_ff + GPOS_W'(out_len_ff))))
      else $error("inconsistent tile descriptor");
`endif

endmodule
`default_nettype wire
